>>> rtl/core/sasm_pkg.sv
// Shared types and constants for the saturating add, subtract and multiply unit.
package sasm_pkg;

	localparam int unsigned DATA_W  = 64;
	localparam int unsigned HALF_W  = DATA_W / 2;
	localparam int unsigned PROD_W  = 2 * DATA_W;
	localparam int unsigned EXACT_W = PROD_W + 1;
	localparam int unsigned SUM_W   = DATA_W + 2;
	localparam int unsigned WID_W   = 7;

	// Operation codes of the kind field; the unused code behaves as multiply.
	localparam logic [1:0] KIND_ADD = 2'd0;
	localparam logic [1:0] KIND_SUB = 2'd1;
	localparam logic [1:0] KIND_MUL = 2'd2;

	// Clamp codes of the clip field.
	localparam logic [1:0] CLIP_NONE = 2'd0;
	localparam logic [1:0] CLIP_MAX  = 2'd1;
	localparam logic [1:0] CLIP_MIN  = 2'd2;

	// Per-item control that travels down the pipeline beside the data.
	typedef struct packed {
		logic              sub;
		logic              mul;
		logic              sgn;
		logic [DATA_W-1:0] maxv;
	} ctl_t;

endpackage

>>> rtl/core/sasm_mul.sv
// Two-stage 64 x 64 unsigned multiplier built from 32 x 32 partial products.
module sasm_mul
	import sasm_pkg::*;
(
	input  logic              clk,
	input  logic              en,
	input  logic              sgn,
	input  logic [DATA_W-1:0] x,
	input  logic [DATA_W-1:0] y,
	output logic [PROD_W-1:0] prod_s3,
	output logic [DATA_W-1:0] corr_s3
);

	logic [DATA_W-1:0] p00_s2;
	logic [DATA_W-1:0] p01_s2;
	logic [DATA_W-1:0] p10_s2;
	logic [DATA_W-1:0] p11_s2;
	logic [DATA_W-1:0] corr_s2;
	logic [DATA_W-1:0] corr_c;

	// Signed operands are taken as unsigned; the high half is then reduced by
	// the other operand for each negative one, modulo two to the 64th.
	always_comb begin
		corr_c = '0;
		if (sgn && x[DATA_W-1]) begin
			corr_c = corr_c + y;
		end
		if (sgn && y[DATA_W-1]) begin
			corr_c = corr_c + x;
		end
	end

	// First stage: the four partial products, each a 32 x 32 product in 64 bits.
	always_ff @(posedge clk) begin
		if (en) begin
			p00_s2  <= DATA_W'(x[HALF_W-1:0]) * DATA_W'(y[HALF_W-1:0]);
			p01_s2  <= DATA_W'(x[HALF_W-1:0]) * DATA_W'(y[DATA_W-1:HALF_W]);
			p10_s2  <= DATA_W'(x[DATA_W-1:HALF_W]) * DATA_W'(y[HALF_W-1:0]);
			p11_s2  <= DATA_W'(x[DATA_W-1:HALF_W]) * DATA_W'(y[DATA_W-1:HALF_W]);
			corr_s2 <= corr_c;
		end
	end

	// Second stage: the outer products sit side by side, the middle ones are added in.
	always_ff @(posedge clk) begin
		if (en) begin
			prod_s3 <= {p11_s2, p00_s2}
				+ {{HALF_W{1'b0}}, p01_s2, {HALF_W{1'b0}}}
				+ {{HALF_W{1'b0}}, p10_s2, {HALF_W{1'b0}}};
			corr_s3 <= corr_s2;
		end
	end

endmodule

>>> rtl/core/saturating_add_sub_mul.sv
// Saturating add, subtract and multiply: five register stages, one item per cycle.
// An accepted input item passes through stages one to five before its result item is valid.
// A new item is accepted every cycle; the whole pipeline holds while a result waits.
// The 128-bit product is assembled in the stage after the 32 x 32 multipliers.
// Reset clears the stage valid bits only; no item is in flight after reset.
module saturating_add_sub_mul
	import sasm_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        kind,
	input  logic [DATA_W-1:0] operand_a,
	input  logic [DATA_W-1:0] operand_b,
	input  logic [WID_W-1:0]  width,
	input  logic              signed_mode,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [DATA_W-1:0] result,
	output logic [1:0]        clip
);

	logic adv;
	logic v_s1, v_s2, v_s3, v_s4, v_s5;

	logic [WID_W-1:0]  n_c;
	logic [DATA_W-1:0] mask_c;
	logic [DATA_W-1:0] x_c, y_c;
	ctl_t              ctl_c;

	logic [DATA_W-1:0] x_s1, y_s1;
	ctl_t              ctl_s1, ctl_s2, ctl_s3, ctl_s4;
	logic [SUM_W-1:0]  sum_s2, sum_s3;
	logic [PROD_W-1:0] prod_s3;
	logic [DATA_W-1:0] corr_s3;
	logic [DATA_W-1:0] hi_c;
	logic [EXACT_W-1:0] exact_c, exact_s4;
	logic [EXACT_W-1:0] maxv_c, minv_c;
	logic              above_c, below_c;
	logic              sgn_s5;
	logic [DATA_W-1:0] result_s5;
	logic [1:0]        clip_s5;
	logic              ex, ey;

	// The pipeline moves as one unless a finished item is held at the output.
	assign adv       = !(v_s5 && out_stall);
	assign in_stall  = !adv;
	assign out_valid = v_s5;
	assign result    = result_s5;
	assign clip      = clip_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// Stage one: clamp the width into range, extend both operands from it and decode the kind.
	always_comb begin
		n_c = width;
		if (width == '0) begin
			n_c = WID_W'(1);
		end else if (width > WID_W'(DATA_W)) begin
			n_c = WID_W'(DATA_W);
		end
		mask_c = ~({DATA_W{1'b1}} << n_c);
		x_c = operand_a & mask_c;
		y_c = operand_b & mask_c;
		if (signed_mode && operand_a[6'(n_c - WID_W'(1))]) begin
			x_c = x_c | ~mask_c;
		end
		if (signed_mode && operand_b[6'(n_c - WID_W'(1))]) begin
			y_c = y_c | ~mask_c;
		end
		ctl_c.sub  = (kind == KIND_SUB);
		ctl_c.mul  = (kind != KIND_ADD) && (kind != KIND_SUB);
		ctl_c.sgn  = signed_mode;
		ctl_c.maxv = signed_mode ? (mask_c >> 1) : mask_c;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s1   <= x_c;
			y_s1   <= y_c;
			ctl_s1 <= ctl_c;
		end
	end

	// Stages two and three: multiplier, with the sum or difference carried beside it.
	sasm_mul u_mul (
		.clk     (clk),
		.en      (adv),
		.sgn     (ctl_s1.sgn),
		.x       (x_s1),
		.y       (y_s1),
		.prod_s3 (prod_s3),
		.corr_s3 (corr_s3)
	);

	assign ex = ctl_s1.sgn & x_s1[DATA_W-1];
	assign ey = ctl_s1.sgn & y_s1[DATA_W-1];

	always_ff @(posedge clk) begin
		if (adv) begin
			if (ctl_s1.sub) begin
				sum_s2 <= {ex, ex, x_s1} - {ey, ey, y_s1};
			end else begin
				sum_s2 <= {ex, ex, x_s1} + {ey, ey, y_s1};
			end
			ctl_s2 <= ctl_s1;
			sum_s3 <= sum_s2;
			ctl_s3 <= ctl_s2;
		end
	end

	// Stage four: form the exact result as a 129-bit two's complement value.
	always_comb begin
		hi_c = prod_s3[PROD_W-1:DATA_W] - corr_s3;
		if (!ctl_s3.mul) begin
			exact_c = {{(EXACT_W-SUM_W){sum_s3[SUM_W-1]}}, sum_s3};
		end else if (ctl_s3.sgn) begin
			exact_c = {hi_c[DATA_W-1], hi_c, prod_s3[DATA_W-1:0]};
		end else begin
			exact_c = {1'b0, prod_s3};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			exact_s4 <= exact_c;
			ctl_s4   <= ctl_s3;
		end
	end

	// Stage five: compare against the limits of the width and clamp.
	always_comb begin
		maxv_c  = {{(EXACT_W-DATA_W){1'b0}}, ctl_s4.maxv};
		minv_c  = ctl_s4.sgn ? {{(EXACT_W-DATA_W){1'b1}}, ~ctl_s4.maxv} : '0;
		above_c = $signed(exact_s4) > $signed(maxv_c);
		below_c = $signed(exact_s4) < $signed(minv_c);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sgn_s5 <= ctl_s4.sgn;
			if (above_c) begin
				result_s5 <= ctl_s4.maxv;
				clip_s5   <= CLIP_MAX;
			end else if (below_c) begin
				result_s5 <= minv_c[DATA_W-1:0];
				clip_s5   <= CLIP_MIN;
			end else begin
				result_s5 <= exact_s4[DATA_W-1:0];
				clip_s5   <= CLIP_NONE;
			end
		end
	end

	// An item in the last internal stage reaches the output on the next advance.
	a_s4_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		adv && v_s4 |=> out_valid)
		else $error("item lost between stage four and the output");

	// An unsigned result clamped low is always zero.
	a_unsigned_min: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && clip == CLIP_MIN && !sgn_s5 |-> result == '0)
		else $error("unsigned low clamp is not zero");

	// The largest signed value of any width is non-negative in 64 bits.
	a_signed_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && clip == CLIP_MAX && sgn_s5 |-> !result[DATA_W-1])
		else $error("signed high clamp is negative");

endmodule

>>> tb/sv/saturating_add_sub_mul_check.sv
// Result checker for the saturating add, subtract and multiply unit: predicts and compares.
module saturating_add_sub_mul_check
	import sasm_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_stall,
	input  logic [1:0]        kind,
	input  logic [DATA_W-1:0] operand_a,
	input  logic [DATA_W-1:0] operand_b,
	input  logic [WID_W-1:0]  width,
	input  logic              signed_mode,
	input  logic              out_valid,
	input  logic              out_stall,
	input  logic [DATA_W-1:0] result,
	input  logic [1:0]        clip,
	output int                mismatches,
	output int                waiting
);

	typedef struct {
		logic [DATA_W-1:0] result;
		logic [1:0]        clip;
	} sat_res_t;

	// Results predicted for accepted items, oldest first.
	sat_res_t sat_results_q[$];
	sat_res_t want;
	int       bad_count;

	// Exact arithmetic on the extended operands, then clamping to the range of the width.
	function automatic sat_res_t saturate_op(input logic [1:0] op,
			input logic [DATA_W-1:0] a, input logic [DATA_W-1:0] b,
			input logic [WID_W-1:0] w, input logic sgn);
		int unsigned         n;
		logic [DATA_W-1:0]   mask;
		logic signed [129:0] xa;
		logic signed [129:0] xb;
		logic signed [129:0] exact;
		logic signed [129:0] hi_lim;
		logic signed [129:0] lo_lim;
		sat_res_t            r;
		// A width of zero behaves as one bit, anything above 64 as 64 bits.
		n = 32'(w);
		if (n == 0) begin
			n = 1;
		end else if (n > DATA_W) begin
			n = DATA_W;
		end
		mask = (n == DATA_W) ? '1 : ((64'd1 << n) - 64'd1);
		xa = {66'd0, a & mask};
		xb = {66'd0, b & mask};
		if (sgn && a[n-1]) begin
			xa = xa - (130'd1 << n);
		end
		if (sgn && b[n-1]) begin
			xb = xb - (130'd1 << n);
		end
		hi_lim = sgn ? (130'd1 << (n - 1)) - 130'd1 : (130'd1 << n) - 130'd1;
		lo_lim = sgn ? -(130'd1 << (n - 1)) : 130'd0;
		// The unused operation code behaves as multiply.
		case (op)
			KIND_ADD: begin
				exact = xa + xb;
			end
			KIND_SUB: begin
				exact = xa - xb;
			end
			default: begin
				exact = xa * xb;
			end
		endcase
		if (exact > hi_lim) begin
			r.result = hi_lim[DATA_W-1:0];
			r.clip   = CLIP_MAX;
		end else if (exact < lo_lim) begin
			r.result = lo_lim[DATA_W-1:0];
			r.clip   = CLIP_MIN;
		end else begin
			r.result = exact[DATA_W-1:0];
			r.clip   = CLIP_NONE;
		end
		return r;
	endfunction

	// Compare each accepted result with the oldest prediction, then record new items.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mismatches <= 0;
			waiting    <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (sat_results_q.size() == 0) begin
					bad_count = bad_count + 1;
					if (bad_count <= 10) begin
						$display("unexpected result %h clip %0d with no item outstanding",
							result, clip);
					end
				end else begin
					want = sat_results_q.pop_front();
					if (result !== want.result || clip !== want.clip) begin
						bad_count = bad_count + 1;
						if (bad_count <= 10) begin
							$display("mismatch: result exp %h got %h, clip exp %0d got %0d",
								want.result, result, want.clip, clip);
						end
					end
				end
			end
			if (in_valid && !in_stall) begin
				sat_results_q.push_back(saturate_op(kind, operand_a, operand_b, width,
					signed_mode));
			end
			mismatches <= bad_count;
			waiting    <= sat_results_q.size();
		end
	end

endmodule

>>> tb/sv/saturating_add_sub_mul_tb.sv
// Testbench top for the saturating add, subtract and multiply unit: stimulus and verdict.
module saturating_add_sub_mul_tb;
	import sasm_pkg::*;

	localparam logic [1:0]        KIND_SPARE = 2'd3;
	localparam logic [DATA_W-1:0] ALL_ONES   = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam logic [DATA_W-1:0] S64_MIN    = 64'h8000_0000_0000_0000;
	localparam logic [DATA_W-1:0] S64_MAX    = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam int                HOLD_LEN   = 60;

	logic              clk;
	logic              arst_n      = 1'b0;
	logic              in_valid    = 1'b0;
	logic              in_stall;
	logic [1:0]        kind        = KIND_ADD;
	logic [DATA_W-1:0] operand_a   = '0;
	logic [DATA_W-1:0] operand_b   = '0;
	logic [WID_W-1:0]  width       = 7'd1;
	logic              signed_mode = 1'b0;
	logic              out_valid;
	logic              out_stall   = 1'b0;
	logic [DATA_W-1:0] result;
	logic [1:0]        clip;

	int mismatches;
	int waiting;
	int idle_pct  = 0;
	int stall_pct = 0;
	int hold_cycles = 0;
	logic hold_req   = 1'b0;
	logic hold_taken = 1'b0;

	saturating_add_sub_mul u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.kind        (kind),
		.operand_a   (operand_a),
		.operand_b   (operand_b),
		.width       (width),
		.signed_mode (signed_mode),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.result      (result),
		.clip        (clip)
	);

	saturating_add_sub_mul_check u_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.kind        (kind),
		.operand_a   (operand_a),
		.operand_b   (operand_b),
		.width       (width),
		.signed_mode (signed_mode),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.result      (result),
		.clip        (clip),
		.mismatches  (mismatches),
		.waiting     (waiting)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Run limit, far beyond the slowest correct run.
	initial begin
		#2000000;
		$display("== FAIL ==");
		$finish;
	end

	// Receiver: one long hold-off once it is requested, otherwise random stalls.
	always @(posedge clk) begin
		if (hold_req && !hold_taken) begin
			hold_taken  <= 1'b1;
			hold_cycles <= HOLD_LEN - 1;
			out_stall   <= 1'b1;
		end else if (hold_cycles != 0) begin
			out_stall   <= 1'b1;
			hold_cycles <= hold_cycles - 1;
		end else begin
			out_stall <= ($urandom_range(0, 99) < stall_pct);
		end
	end

	// Offer one item after a random gap and wait until it is accepted.
	task automatic offer_item(input logic [1:0] k, input logic [DATA_W-1:0] a,
			input logic [DATA_W-1:0] b, input logic [WID_W-1:0] w, input logic s);
		while ($urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		kind        <= k;
		operand_a   <= a;
		operand_b   <= b;
		width       <= w;
		signed_mode <= s;
		in_valid    <= 1'b1;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
	endtask

	// Operand with its interesting part in the low n bits and, at random, junk above.
	function automatic logic [DATA_W-1:0] pick_operand(input int unsigned n);
		logic [DATA_W-1:0] v;
		logic [DATA_W-1:0] top_bit;
		top_bit = 64'd1 << (n - 1);
		case ($urandom_range(0, 6))
			0: begin
				v = {$urandom, $urandom};
			end
			1: begin
				v = 64'($urandom_range(0, 7));
			end
			2: begin
				v = ALL_ONES;
			end
			3: begin
				v = top_bit;
			end
			4: begin
				v = top_bit - 64'd1;
			end
			5: begin
				v = {$urandom, $urandom} & ((64'd1 << (n / 2)) - 64'd1);
				if ($urandom_range(0, 1) == 1) begin
					v = -v;
				end
			end
			default: begin
				v = {$urandom, $urandom} >> $urandom_range(0, 63);
			end
		endcase
		if ($urandom_range(0, 1) == 1) begin
			v = v | ({$urandom, $urandom} << n);
		end
		return v;
	endfunction

	// Random item: mostly legal widths, some out-of-range widths and the spare code.
	task automatic random_item();
		logic [WID_W-1:0] w;
		logic [1:0]       k;
		int unsigned      n;
		case ($urandom_range(0, 15))
			0: begin
				w = WID_W'($urandom_range(0, 127));
			end
			1: begin
				w = 7'd64;
			end
			2: begin
				w = 7'd1;
			end
			default: begin
				w = WID_W'($urandom_range(1, 64));
			end
		endcase
		n = (w == 0) ? 1 : ((w > DATA_W) ? DATA_W : 32'(w));
		k = ($urandom_range(0, 9) == 0) ? KIND_SPARE : 2'($urandom_range(0, 2));
		offer_item(k, pick_operand(n), pick_operand(n), w, 1'($urandom_range(0, 1)));
	endtask

	// Directed extremes, then random phases with different idling, then the drain.
	initial begin
		int guard;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Saturation at both ends for every operation, and the odd width and code cases.
		offer_item(KIND_ADD, ALL_ONES, 64'd1, 7'd64, 1'b0);
		offer_item(KIND_ADD, S64_MAX, S64_MAX, 7'd64, 1'b1);
		offer_item(KIND_ADD, S64_MIN, S64_MIN, 7'd64, 1'b1);
		offer_item(KIND_ADD, 64'hABCD_EF01_2345_6700, 64'hFFFF_0000_0000_0000, 7'd8, 1'b0);
		offer_item(KIND_SUB, 64'd3, 64'd5, 7'd16, 1'b0);
		offer_item(KIND_SUB, S64_MIN, 64'd1, 7'd64, 1'b1);
		offer_item(KIND_SUB, S64_MAX, ALL_ONES, 7'd64, 1'b1);
		offer_item(KIND_SUB, ALL_ONES, ALL_ONES, 7'd64, 1'b0);
		offer_item(KIND_MUL, ALL_ONES, ALL_ONES, 7'd64, 1'b0);
		offer_item(KIND_MUL, S64_MIN, S64_MIN, 7'd64, 1'b1);
		offer_item(KIND_MUL, S64_MIN, ALL_ONES, 7'd64, 1'b1);
		offer_item(KIND_MUL, S64_MIN, 64'd1, 7'd64, 1'b1);
		// Multiply at widths of 32 and above: signed at 33 and 63 bits, unsigned at 32 bits.
		offer_item(KIND_MUL, 64'h1_0000_0000, 64'h0_FFFF_FFFF, 7'd33, 1'b1);
		offer_item(KIND_MUL, 64'h4000_0000_0000_0000, ALL_ONES, 7'd63, 1'b1);
		offer_item(KIND_MUL, 64'hFFFF_FFFF, 64'hFFFF_FFFF, 7'd32, 1'b0);
		// One-bit width, signed and unsigned.
		offer_item(KIND_ADD, 64'd1, 64'd1, 7'd1, 1'b1);
		offer_item(KIND_ADD, 64'd1, 64'd1, 7'd1, 1'b0);
		// Width zero acts as one bit; widths above 64 act as 64.
		offer_item(KIND_ADD, 64'd1, 64'd1, 7'd0, 1'b0);
		offer_item(KIND_MUL, S64_MIN, ALL_ONES, 7'd127, 1'b1);
		offer_item(KIND_SUB, 64'd0, 64'd1, 7'd65, 1'b0);
		// The spare operation code acts as multiply.
		offer_item(KIND_SPARE, 64'h100, 64'h100, 7'd16, 1'b1);
		offer_item(KIND_MUL, 64'hFD, 64'd5, 7'd8, 1'b1);

		// Random phases: no idling, sender idle, receiver stalling, both lightly.
		idle_pct  = 0;
		stall_pct = 0;
		repeat (200) random_item();
		idle_pct  = 82;
		repeat (200) random_item();
		idle_pct  = 0;
		stall_pct = 82;
		repeat (200) random_item();
		idle_pct  = 6;
		stall_pct = 6;
		repeat (200) random_item();

		// Long receiver hold-off while items keep coming, so the pipeline fills and stalls.
		idle_pct  = 0;
		stall_pct = 0;
		hold_req <= 1'b1;
		repeat (50) random_item();

		// Drain every outstanding result, then allow for the pipeline latency.
		in_valid <= 1'b0;
		@(posedge clk);
		guard = 0;
		while (waiting != 0 && guard < 20000) begin
			@(posedge clk);
			guard = guard + 1;
		end
		repeat (20) @(posedge clk);
		if (mismatches == 0 && waiting == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

>>> filelist.f
rtl/core/sasm_pkg.sv
rtl/core/sasm_mul.sv
rtl/core/saturating_add_sub_mul.sv
tb/sv/saturating_add_sub_mul_check.sv
tb/sv/saturating_add_sub_mul_tb.sv
